/* sv/qphi_pkg.sv */
// Shared types, constants and helpers for the quadratic-probe hash insert block.
// No dependencies; every other file refers to this package by scoped names.
package qphi_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 6;
    localparam int MOD_W  = 7;
    localparam int COEF_W = 8;
    localparam int CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEFF = 2'd2;

    // Reset values of the configuration registers
    localparam logic [MOD_W-1:0]  RST_TABLE_SIZE = 7'd64;
    localparam logic [COEF_W-1:0] RST_COEFF      = 8'd1;

    // Start request into the serial remainder unit
    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  operand;   // left aligned, MSB first
        logic [CNT_W-1:0]  nbits;
    } mod_cmd_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } mod_stat_t;

    // One compare-subtract step; v must be below 2*m.
    function automatic logic [MOD_W-1:0] cond_sub(input logic [MOD_W:0] v,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0] diff;
        begin
            diff = v - {1'b0, m};
            if (v >= {1'b0, m})
            begin
                cond_sub = diff[MOD_W-1:0];
            end
            else
            begin
                cond_sub = v[MOD_W-1:0];
            end
        end
    endfunction

endpackage

/* sv/qphi_if.sv */
// Handshake channels of the hash insert block: key requests in, slot results out.
// Depends on qphi_pkg for payload widths.
interface qphi_key_if;
    logic                           valid;
    logic                           ready;
    logic signed [qphi_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface qphi_res_if;
    logic                        valid;
    logic                        ready;
    logic [qphi_pkg::SLOT_W-1:0] slot;
    logic                        table_full;

    modport source (output valid, output slot, output table_full, input ready);
    modport sink   (input valid, input slot, input table_full, output ready);
endinterface

/* sv/quadratic_probe_hash_insert_top.sv */
// Quadratic-probe hash insert: top level with sequencer and configuration registers.
// Depends on qphi_pkg, qphi_if, qphi_modu and qphi_store.
//
// Each key request is inserted into an open-addressing table of TABLE_DEPTH slots,
// of which table_size (clamped to 1..min(TABLE_DEPTH,127)) are in use. Probe i visits
// (base + c1*i + c2*i*i) mod m, with base the non-negative remainder of the signed
// key; the key lands in the first empty slot, or table_full is returned when all m
// probes hit occupied slots. After reset the block sweeps the store empty before it
// takes the first key. For each key the single bit-serial remainder unit reduces the
// 32-bit key magnitude, then each 8-bit coefficient, each run followed by the
// handover of its remainder; then comes one setup state; then every probe takes one
// store read state plus one decide state on the shared store port; then the result
// is handed over once the output register is free, and the block returns to idle to
// take the next key. Only one key is in flight at a time, but a finished result
// waits in an output register, so the next key is taken while the previous result
// is still unclaimed. Configuration writes are meant for idle periods; slots above a
// shrunk table_size keep their contents.
module quadratic_probe_hash_insert_top
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    qphi_key_if.sink                          key_chan,
    qphi_res_if.source                        result_chan,
    input  logic                              cfg_wr_en,
    input  logic [qphi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qphi_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int MOD_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam int MW = qphi_pkg::MOD_W;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_MOD_KEY = 9'b000000100,
        ST_MOD_LIN = 9'b000001000,
        ST_MOD_SQR = 9'b000010000,
        ST_SETUP   = 9'b000100000,
        ST_READ    = 9'b001000000,
        ST_CHECK   = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [MW-1:0]                   table_size_reg;
    logic [qphi_pkg::COEF_W-1:0]     linear_coeff_reg;
    logic [qphi_pkg::COEF_W-1:0]     square_coeff_reg;

    // Per-item working registers
    logic [AW-1:0]                   clr_addr_reg;
    logic [qphi_pkg::KEY_W-1:0]      key_reg;
    logic                            neg_reg;
    logic [MW-1:0]                   pos_reg, pos_next;
    logic [MW-1:0]                   lin_reg;
    logic [MW-1:0]                   sqr_reg;
    logic [MW-1:0]                   step_reg, step_next;
    logic [MW-1:0]                   dbl_reg;
    logic [MW-1:0]                   probe_reg;
    logic [qphi_pkg::SLOT_W-1:0]     pend_slot_reg;
    logic                            pend_full_reg;

    // Output register
    logic                            out_valid_reg;
    logic [qphi_pkg::SLOT_W-1:0]     out_slot_reg;
    logic                            out_full_reg;

    logic [MW-1:0]                   modulus;
    logic [qphi_pkg::KEY_W-1:0]      key_mag;
    logic [MW-1:0]                   base_fix;
    qphi_pkg::mod_cmd_t              mod_cmd;
    qphi_pkg::mod_stat_t             mod_stat;
    logic                            store_we;
    logic [AW-1:0]                   store_addr;
    logic                            store_wr_occ;
    logic [qphi_pkg::KEY_W-1:0]      store_wr_key;
    logic                            store_rd_occ;
    logic                            key_take;
    logic                            out_free;

    // Clamp the modulus to 1..min(TABLE_DEPTH, 127)
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            modulus = MW'(1);
        end
        else if (table_size_reg > MW'(MOD_CAP))
        begin
            modulus = MW'(MOD_CAP);
        end
        else
        begin
            modulus = table_size_reg;
        end
    end

    assign key_take = (state_reg == ST_IDLE) && key_chan.valid;
    assign key_mag  = key_chan.key[qphi_pkg::KEY_W-1] ? (~$unsigned(key_chan.key) + 1'b1)
                                                       : $unsigned(key_chan.key);

    // Negative key with a nonzero remainder folds back into range
    assign base_fix = (neg_reg && (mod_stat.rem != '0)) ? (modulus - mod_stat.rem)
                                                        : mod_stat.rem;

    // Remainder unit start requests: key magnitude, then c1, then c2
    always_comb
    begin
        mod_cmd = '0;
        if (key_take)
        begin
            mod_cmd.start   = 1'b1;
            mod_cmd.operand = key_mag;
            mod_cmd.nbits   = qphi_pkg::CNT_W'(qphi_pkg::KEY_W);
        end
        else if ((state_reg == ST_MOD_KEY) && mod_stat.done)
        begin
            mod_cmd.start   = 1'b1;
            mod_cmd.operand = {linear_coeff_reg, {(qphi_pkg::KEY_W - qphi_pkg::COEF_W){1'b0}}};
            mod_cmd.nbits   = qphi_pkg::CNT_W'(qphi_pkg::COEF_W);
        end
        else if ((state_reg == ST_MOD_LIN) && mod_stat.done)
        begin
            mod_cmd.start   = 1'b1;
            mod_cmd.operand = {square_coeff_reg, {(qphi_pkg::KEY_W - qphi_pkg::COEF_W){1'b0}}};
            mod_cmd.nbits   = qphi_pkg::CNT_W'(qphi_pkg::COEF_W);
        end
    end

    qphi_modu u_modu
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mod_cmd),
        .modulus (modulus),
        .stat    (mod_stat)
    );

    // Advance the probe: pos += step, step += 2*c2, both mod m
    assign pos_next  = qphi_pkg::cond_sub({1'b0, pos_reg} + {1'b0, step_reg}, modulus);
    assign step_next = qphi_pkg::cond_sub({1'b0, step_reg} + {1'b0, dbl_reg}, modulus);

    // Store port: clearing sweep, probe reads, and the claiming write
    assign store_we     = (state_reg == ST_CLEAR) || ((state_reg == ST_CHECK) && !store_rd_occ);
    assign store_addr   = (state_reg == ST_CLEAR) ? clr_addr_reg : AW'(pos_reg);
    assign store_wr_occ = (state_reg != ST_CLEAR);
    assign store_wr_key = (state_reg == ST_CLEAR) ? '1 : key_reg;

    qphi_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store
    (
        .clk    (clk),
        .wr_en  (store_we),
        .addr   (store_addr),
        .wr_occ (store_wr_occ),
        .wr_key (store_wr_key),
        .rd_occ (store_rd_occ)
    );

    assign out_free = !out_valid_reg || result_chan.ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (key_chan.valid)
                begin
                    state_next = ST_MOD_KEY;
                end
            end
            ST_MOD_KEY:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_MOD_LIN;
                end
            end
            ST_MOD_LIN:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_MOD_SQR;
                end
            end
            ST_MOD_SQR:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!store_rd_occ || (probe_reg == modulus - 1'b1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            table_size_reg   <= qphi_pkg::RST_TABLE_SIZE;
            linear_coeff_reg <= qphi_pkg::RST_COEFF;
            square_coeff_reg <= qphi_pkg::RST_COEFF;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    qphi_pkg::REG_TABLE_SIZE:   table_size_reg   <= cfg_data[MW-1:0];
                    qphi_pkg::REG_LINEAR_COEFF: linear_coeff_reg <= cfg_data;
                    qphi_pkg::REG_SQUARE_COEFF: square_coeff_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (key_take)
        begin
            key_reg <= $unsigned(key_chan.key);
            neg_reg <= key_chan.key[qphi_pkg::KEY_W-1];
        end
        if ((state_reg == ST_MOD_KEY) && mod_stat.done)
        begin
            pos_reg <= base_fix;
        end
        if ((state_reg == ST_MOD_LIN) && mod_stat.done)
        begin
            lin_reg <= mod_stat.rem;
        end
        if ((state_reg == ST_MOD_SQR) && mod_stat.done)
        begin
            sqr_reg <= mod_stat.rem;
        end
        if (state_reg == ST_SETUP)
        begin
            // step for probe 0 -> 1 is c1 + c2; it grows by 2*c2 each probe
            step_reg  <= qphi_pkg::cond_sub({1'b0, lin_reg} + {1'b0, sqr_reg}, modulus);
            dbl_reg   <= qphi_pkg::cond_sub({sqr_reg, 1'b0}, modulus);
            probe_reg <= '0;
        end
        if (state_reg == ST_CHECK)
        begin
            if (!store_rd_occ)
            begin
                pend_slot_reg <= pos_reg[qphi_pkg::SLOT_W-1:0];
                pend_full_reg <= 1'b0;
            end
            else if (probe_reg == modulus - 1'b1)
            begin
                pend_slot_reg <= '0;
                pend_full_reg <= 1'b1;
            end
            else
            begin
                pos_reg   <= pos_next;
                step_reg  <= step_next;
                probe_reg <= probe_reg + 1'b1;
            end
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_slot_reg <= pend_slot_reg;
            out_full_reg <= pend_full_reg;
        end
    end

    assign key_chan.ready         = (state_reg == ST_IDLE);
    assign result_chan.valid      = out_valid_reg;
    assign result_chan.slot       = out_slot_reg;
    assign result_chan.table_full = out_full_reg;

endmodule

/* sv/qphi_modu.sv */
// Bit-serial remainder unit: one shift and compare-subtract per cycle.
// Depends on qphi_pkg (mod_cmd_t, mod_stat_t, cond_sub).
module qphi_modu
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  qphi_pkg::mod_cmd_t           cmd,
    input  logic [qphi_pkg::MOD_W-1:0]   modulus,
    output qphi_pkg::mod_stat_t          stat
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [qphi_pkg::CNT_W-1:0]   cnt_reg;
    logic [qphi_pkg::KEY_W-1:0]   shift_reg;
    logic [qphi_pkg::MOD_W-1:0]   rem_reg;
    logic [qphi_pkg::MOD_W-1:0]   rem_next;

    assign rem_next = qphi_pkg::cond_sub({rem_reg, shift_reg[qphi_pkg::KEY_W-1]}, modulus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == qphi_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            shift_reg <= cmd.operand;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[qphi_pkg::KEY_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

/* sv/qphi_store.sv */
// Slot store: occupancy bits and stored keys, one shared address port.
// Read data is registered; depends on qphi_pkg for the key width.
module qphi_store
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  logic                         wr_occ,
    input  logic [qphi_pkg::KEY_W-1:0]   wr_key,
    output logic                         rd_occ
);

    logic                       occ_mem [TABLE_DEPTH];
    logic [qphi_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic                       rd_occ_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[addr] <= wr_occ;
            key_mem[addr] <= wr_key;
        end
        rd_occ_reg <= occ_mem[addr];
    end

    assign rd_occ = rd_occ_reg;

endmodule
